### sv/rcps_pkg.sv
package rcps_pkg;

    // Fixed widths of the item fields and of the internal arithmetic.
    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int DIR_W     = COORD_W + 1;
    localparam int PROD_W    = DIR_W + COORD_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int MAG_W     = DOT_W - 1;
    localparam int NUM_W     = MAG_W + FRAC_W;
    localparam int STEP_W    = COORD_W - 1;
    localparam int IDX_W     = 4;
    localparam int FC_W      = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_A_W   = 2;
    localparam int IN_DATA_W = 200;
    localparam int OUT_DATA_W = 40;

    localparam logic [STEP_W-1:0] STEP_CAP = '1;

    // Request kinds carried on the input sideband.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_A_W-1:0] CFG_FACE_COUNT = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_BACKWARD   = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_PAR_THR    = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_MIN_STEP   = 2'd3;

    typedef struct packed {
        logic [FC_W-1:0]  face_count;
        logic             backward;
        logic [CFG_W-1:0] par_thr;
        logic [CFG_W-1:0] min_step;
    } cfg_t;

    // One face of a query as handed from the front to the back.
    typedef struct packed {
        logic signed [DOT_W-1:0] off;
        logic signed [DOT_W-1:0] proj;
        logic                    empty;
        logic                    last;
    } face_rec_t;

endpackage

### sv/ray_convex_polyhedron_step_top.sv
// After a load item the next item is accepted in the following cycle. A query
// walks each face in the front through F_OFF, F_PROJ and F_PUSH (shared
// three-multiplier unit) and in the back through B_POP, B_SAT, B_DIV (the
// one-bit-a-cycle divider) and B_UPD; skipped or on-plane faces bypass B_DIV.
// Reset (aresetn low at a clock edge) clears control state and restores the
// registers to their defaults; the face table holds nothing valid until loaded.
module ray_convex_polyhedron_step_top
    import rcps_pkg::*;
#(
    parameter int MAX_FACES = 16
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_A_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // face_index, point_x, point_y, point_z, vec_x, vec_y, vec_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // step_length, step_unbounded, inside_medium
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t      cfg_reg;
    face_rec_t fe_rec, be_rec;
    logic      fe_valid, fe_ready, be_valid, be_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.face_count <= FC_W'(1);
            cfg_reg.backward   <= 1'b0;
            cfg_reg.par_thr    <= '0;
            cfg_reg.min_step   <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FACE_COUNT: cfg_reg.face_count <= cfg_wdata[FC_W-1:0];
                CFG_BACKWARD:   cfg_reg.backward   <= cfg_wdata[0];
                CFG_PAR_THR:    cfg_reg.par_thr    <= cfg_wdata;
                CFG_MIN_STEP:   cfg_reg.min_step   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rcps_front #(.MAX_FACES(MAX_FACES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .rec_valid (fe_valid),
        .rec_ready (fe_ready),
        .rec       (fe_rec)
    );

    rcps_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_rec),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_data  (be_rec)
    );

    rcps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .rec_valid (be_valid),
        .rec_ready (be_ready),
        .rec       (be_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // An unbounded step always reports the saturated length.
    a_unb_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STEP_W] |-> m_tdata[STEP_W-1:0] == STEP_CAP)
        else $error("unbounded step without saturated length");

    // A finite step is never below the floor.
    a_min_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[STEP_W] |-> m_tdata[STEP_W-1:0] >= STEP_W'(cfg_reg.min_step))
        else $error("finite step below minimum");

    // Padding bits of the result stay clear.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:STEP_W+2] == '0)
        else $error("result padding not zero");

endmodule

### sv/rcps_fifo.sv
module rcps_fifo
    import rcps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  face_rec_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output face_rec_t out_data
);

    face_rec_t  mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 3'd4);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage of queued face records.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule

### sv/rcps_front.sv
module rcps_front
    import rcps_pkg::*;
#(
    parameter int MAX_FACES = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output face_rec_t            rec
);

    localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CW = $clog2(MAX_FACES + 1);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_OFF  = 4'b0010,
        F_PROJ = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [AW-1:0] k_reg, k_next;
    logic [CW-1:0] used_reg;
    logic          empty_reg;

    logic [IDX_W-1:0]          face_index;
    logic signed [COORD_W-1:0] in_p [3];
    logic signed [COORD_W-1:0] in_v [3];
    logic signed [COORD_W-1:0] pos_reg [3];
    logic signed [DIR_W-1:0]   dir_reg [3];

    logic signed [COORD_W-1:0] org_mem [3][MAX_FACES];
    logic signed [COORD_W-1:0] nrm_mem [3][MAX_FACES];
    logic signed [COORD_W-1:0] org_rd  [3];
    logic signed [COORD_W-1:0] nrm_rd  [3];

    logic signed [DIR_W-1:0]  opa [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [DOT_W-1:0]  prod_sum;
    logic signed [DOT_W-1:0]  off_reg;

    logic [7:0] used8;
    logic       accept, load_ok, last_face;

    assign face_index = s_tdata[IDX_W-1:0];
    assign in_p[0] = s_tdata[35:4];
    assign in_p[1] = s_tdata[67:36];
    assign in_p[2] = s_tdata[99:68];
    assign in_v[0] = s_tdata[131:100];
    assign in_v[1] = s_tdata[163:132];
    assign in_v[2] = s_tdata[195:164];

    assign s_tready  = (state_reg == F_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_ok   = 8'(face_index) < 8'(MAX_FACES);
    assign used8     = (8'(cfg.face_count) > 8'(MAX_FACES)) ? 8'(MAX_FACES)
                                                            : 8'(cfg.face_count);
    assign last_face = empty_reg || ((8'(k_reg) + 8'd1) == 8'(used_reg));

    // Face table: written by loads, read one slot ahead of the walk.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (accept && s_tuser == REQ_LOAD && load_ok) begin
                org_mem[i][AW'(8'(face_index))] <= in_p[i];
                nrm_mem[i][AW'(8'(face_index))] <= in_v[i];
            end
            org_rd[i] <= org_mem[i][k_next];
            nrm_rd[i] <= nrm_mem[i][k_next];
        end
    end

    // Shared multipliers: offset terms first, then projection terms.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (state_reg == F_OFF) begin
                opa[i] = DIR_W'(pos_reg[i]) - DIR_W'(org_rd[i]);
            end else begin
                opa[i] = dir_reg[i];
            end
        end
    end

    assign prod_sum = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            prod_reg[i] <= opa[i] * nrm_rd[i];
        end
        if (state_reg == F_PROJ) begin
            off_reg <= prod_sum;
        end else if (state_reg == F_IDLE) begin
            off_reg <= '0;
        end
        if (accept && s_tuser == REQ_QUERY) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= in_p[i];
                dir_reg[i] <= cfg.backward ? -DIR_W'(in_v[i]) : DIR_W'(in_v[i]);
            end
        end
    end

    // Walk sequencer.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept && s_tuser == REQ_QUERY) begin
                    k_next     = '0;
                    state_next = (used8 == 8'd0) ? F_PUSH : F_OFF;
                end
            end
            F_OFF:  state_next = F_PROJ;
            F_PROJ: state_next = F_PUSH;
            F_PUSH: begin
                if (rec_ready) begin
                    if (last_face) begin
                        state_next = F_IDLE;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = F_OFF;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            k_reg     <= '0;
            used_reg  <= '0;
            empty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (accept && s_tuser == REQ_QUERY) begin
                used_reg  <= CW'(used8);
                empty_reg <= (used8 == 8'd0);
            end
        end
    end

    assign rec_valid  = (state_reg == F_PUSH);
    assign rec.off    = off_reg;
    assign rec.proj   = prod_sum;
    assign rec.empty  = empty_reg;
    assign rec.last   = last_face;

endmodule

### sv/rcps_back.sv
module rcps_back
    import rcps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  face_rec_t             rec,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int DEN_X_W = MAG_W + STEP_W;

    typedef enum logic [4:0] {
        B_POP = 5'b00001,
        B_SAT = 5'b00010,
        B_DIV = 5'b00100,
        B_UPD = 5'b01000,
        B_OUT = 5'b10000
    } bstate_t;

    bstate_t state_reg;

    logic [NUM_W-1:0]  num_reg;
    logic [MAG_W-1:0]  den_reg, rem_reg;
    logic [STEP_W-1:0] shift_reg, q_reg;
    logic [4:0]        cnt_reg;
    logic              sat_reg, off_neg_reg, off_zero_reg, proj_pos_reg;
    logic              skip_reg, last_reg;

    logic                     in_flag_reg, have_exit_reg, have_entry_reg;
    logic signed [COORD_W-1:0] exit_reg, entry_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    logic [MAG_W-1:0]   abs_off, abs_proj;
    logic [DEN_X_W-1:0] den_cap;
    logic [MAG_W:0]     rem2;
    logic               ge;
    logic [STEP_W-1:0]  mag;
    logic signed [COORD_W-1:0] hit_len;
    logic [STEP_W-1:0]  min_ext, len;
    logic               unb, med, out_free;

    assign abs_off  = rec.off[DOT_W-1]  ? MAG_W'(-rec.off)  : MAG_W'(rec.off);
    assign abs_proj = rec.proj[DOT_W-1] ? MAG_W'(-rec.proj) : MAG_W'(rec.proj);

    // Saturation test: quotient reaches the cap when num >= den * cap.
    assign den_cap = {den_reg, {STEP_W{1'b0}}} - DEN_X_W'(den_reg);

    // One restoring division step.
    assign rem2 = {rem_reg, shift_reg[STEP_W-1]};
    assign ge   = rem2 >= {1'b0, den_reg};

    // Signed crossing distance, magnitude rounded up.
    assign mag     = sat_reg ? STEP_CAP : q_reg + STEP_W'(rem_reg != '0);
    assign hit_len = off_zero_reg ? '0
                   : (off_neg_reg == proj_pos_reg) ? $signed({1'b0, mag})
                                                   : -$signed({1'b0, mag});

    // Result selection.
    assign min_ext = STEP_W'(cfg.min_step);
    always_comb begin
        len = STEP_CAP;
        unb = 1'b0;
        med = 1'b0;
        if (in_flag_reg && (!have_exit_reg || exit_reg > 0)) begin
            if (have_exit_reg) begin
                len = (exit_reg[STEP_W-1:0] > min_ext) ? exit_reg[STEP_W-1:0] : min_ext;
            end else begin
                unb = 1'b1;
            end
            med = 1'b1;
        end else if (!in_flag_reg && have_entry_reg && entry_reg > 0) begin
            len = (entry_reg[STEP_W-1:0] > min_ext) ? entry_reg[STEP_W-1:0] : min_ext;
        end else begin
            unb = 1'b1;
            med = have_exit_reg && (exit_reg == 0);
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign rec_ready = (state_reg == B_POP);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Per-face datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_POP: begin
                num_reg      <= {abs_off, {FRAC_W{1'b0}}};
                den_reg      <= abs_proj;
                off_neg_reg  <= rec.off[DOT_W-1];
                off_zero_reg <= (rec.off == '0);
                proj_pos_reg <= !rec.proj[DOT_W-1];
                skip_reg     <= rec.empty || (abs_proj <= MAG_W'(cfg.par_thr));
                last_reg     <= rec.last;
                sat_reg      <= 1'b0;
            end
            B_SAT: begin
                sat_reg   <= DEN_X_W'(num_reg) >= den_cap;
                rem_reg   <= MAG_W'(num_reg[NUM_W-1:STEP_W]);
                shift_reg <= num_reg[STEP_W-1:0];
                q_reg     <= '0;
                cnt_reg   <= '0;
            end
            B_DIV: begin
                rem_reg   <= ge ? MAG_W'(rem2 - {1'b0, den_reg}) : rem2[MAG_W-1:0];
                q_reg     <= {q_reg[STEP_W-2:0], ge};
                shift_reg <= {shift_reg[STEP_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg + 5'd1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, running extremes and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_POP;
            in_flag_reg    <= 1'b1;
            have_exit_reg  <= 1'b0;
            have_entry_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            // The waiting item leaves when taken, unless a new one replaces it.
            if (m_tready && state_reg != B_OUT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_POP: begin
                    if (rec_valid) begin
                        if (!rec.off[DOT_W-1] && rec.off != '0) in_flag_reg <= 1'b0;
                        if (rec.empty || (abs_proj <= MAG_W'(cfg.par_thr))
                            || rec.off == '0) begin
                            state_reg <= B_UPD;
                        end else begin
                            state_reg <= B_SAT;
                        end
                    end
                end
                B_SAT: begin
                    state_reg <= (DEN_X_W'(num_reg) >= den_cap) ? B_UPD : B_DIV;
                end
                B_DIV: begin
                    if (cnt_reg == 5'(STEP_W - 1)) state_reg <= B_UPD;
                end
                B_UPD: begin
                    if (!skip_reg) begin
                        if (proj_pos_reg) begin
                            if (!have_exit_reg || hit_len < exit_reg) begin
                                exit_reg      <= hit_len;
                                have_exit_reg <= 1'b1;
                            end
                        end else begin
                            if (!have_entry_reg || hit_len > entry_reg) begin
                                entry_reg      <= hit_len;
                                have_entry_reg <= 1'b1;
                            end
                        end
                    end
                    state_reg <= last_reg ? B_OUT : B_POP;
                end
                B_OUT: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_data_reg   <= OUT_DATA_W'({med, unb, len});
                        in_flag_reg    <= 1'b1;
                        have_exit_reg  <= 1'b0;
                        have_entry_reg <= 1'b0;
                        state_reg      <= B_POP;
                    end
                end
                default: state_reg <= B_POP;
            endcase
        end
    end

endmodule
